FILE: rtl/cartridge_bank_mapper_with_line_irq_assert.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef CARTRIDGE_BANK_MAPPER_WITH_LINE_IRQ_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_LINE_IRQ_ASSERT_SVH
// implication checked every edge outside reset
`define CBM_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
// next-cycle implication
`define CBM_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

FILE: rtl/cbm_pkg.sv
// Package for the bank mapper: opcodes, status codes, CSR indices, mirroring modes, controller states.
// No dependencies.
package cbm_pkg;
   localparam logic [2:0] OP_CPU_RD = 3'd0;
   localparam logic [2:0] OP_CPU_WR = 3'd1;
   localparam logic [2:0] OP_PPU_RD = 3'd2;
   localparam logic [2:0] OP_PPU_WR = 3'd3;
   localparam logic [2:0] OP_TICK   = 3'd4;

   localparam logic [1:0] ST_NONE   = 2'd0;
   localparam logic [1:0] ST_MAPPED = 2'd1;
   localparam logic [1:0] ST_INNER  = 2'd2;

   localparam logic [1:0] CSR_PRG  = 2'd0;
   localparam logic [1:0] CSR_CHR  = 2'd1;
   localparam logic [1:0] CSR_MIRR = 2'd2;

   localparam logic [1:0] MIRR_VERT = 2'd0;
   localparam logic [1:0] MIRR_FOUR = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_MOD  = 5'b00100,
      S_RAM  = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   typedef struct packed {
      logic load;    // capture input word, start
      logic exec;    // run state update, set up modulo
      logic mod_step;
      logic finish;  // form result
   } cmd_type;

   typedef struct packed {
      logic mod_done;
   } stat_type;
endpackage

FILE: rtl/cbm_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module cbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

FILE: rtl/cbm_ctrl.sv
// Controller state machine for the bank mapper.
// Depends on cbm_pkg.
module cbm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  cbm_pkg::stat_type stat,
   output cbm_pkg::cmd_type  cmd
);
   cbm_pkg::state_type state_ff, state_in;
   logic               vld_ff, vld_in;

   // result register frees once taken, so a new word may start meanwhile
   assign req_ready = (state_ff == cbm_pkg::S_IDLE) && (!vld_ff || rsp_ready);
   assign rsp_valid = vld_ff;

   always_comb begin
      state_in     = state_ff;
      vld_in       = vld_ff;
      cmd          = '0;
      if (vld_ff && rsp_ready) vld_in = 1'b0;
      case (state_ff)
         cbm_pkg::S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = cbm_pkg::S_EXEC;
            end
         end
         cbm_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = cbm_pkg::S_MOD;
         end
         cbm_pkg::S_MOD: begin
            cmd.mod_step = 1'b1;
            if (stat.mod_done) state_in = cbm_pkg::S_RAM;
         end
         cbm_pkg::S_RAM: begin
            state_in = cbm_pkg::S_OUT;
         end
         cbm_pkg::S_OUT: begin
            cmd.finish = 1'b1;
            vld_in     = 1'b1;
            state_in   = cbm_pkg::S_IDLE;
         end
         default: state_in = cbm_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbm_pkg::S_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff   <= vld_in;
      end
   end
endmodule

FILE: rtl/cbm_datapath.sv
// Datapath: mapper registers, IRQ counter, bank modulo, work RAM port.
// Depends on cbm_pkg and cbm_ram.
module cbm_datapath #(
   parameter int WORK_RAM_DEPTH = 8192
) (
   input  logic             clock,
   input  logic             reset,
   input  cbm_pkg::cmd_type cmd,
   output cbm_pkg::stat_type stat,
   input  logic [2:0]       req_opcode,
   input  logic [15:0]      req_address,
   input  logic [7:0]       req_write_data,
   input  logic             csr_write,
   input  logic [1:0]       csr_index,
   input  logic [5:0]       csr_data,
   output logic [1:0]       rsp_status,
   output logic [18:0]      rsp_mapped_offset,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_irq_pending,
   output logic [1:0]       rsp_mirroring_mode
);
   localparam int AW = $clog2(WORK_RAM_DEPTH);

   logic [5:0]  prg_ff, chr_ff;
   logic [1:0]  dmir_ff;
   logic [7:0]  bank_ff [8];
   logic [2:0]  sel_ff;
   logic        pswap_ff, cswap_ff, ramen_ff, ramwe_ff;
   logic [1:0]  mir_ff;
   logic [7:0]  latch_ff, cnt_ff;
   logic        irqen_ff, reload_ff, flag_ff;

   logic [2:0]  op_ff;
   logic [15:0] addr_ff;
   logic [7:0]  data_ff;

   // modulo unit: subtract shifted divisor, one bit per step
   logic [7:0]  rem_ff;
   logic [8:0]  div_ff;
   logic [3:0]  shift_ff;
   logic [1:0]  kind_ff;   // 0 none, 1 prg, 2 chr, 3 chr RAM write
   logic [12:0] low_ff;

   logic [1:0]  st_ff;
   logic [7:0]  ram_q;

   logic [6:0]  cnt8k;
   logic [6:0]  last8k;
   logic [15:0] ca;
   logic [7:0]  pbank, cbank;
   logic [8:0]  cnt1k;
   logic        in_ram, ram_we;
   logic [1:0]  st_c;
   logic [1:0]  k_c;
   logic [7:0]  tcnt;

   assign cnt8k  = {(prg_ff == 6'd0) ? 6'd1 : prg_ff, 1'b0};
   assign last8k = cnt8k - 7'd1;
   assign cnt1k  = {(chr_ff == 6'd0) ? 6'd1 : chr_ff, 3'b000};
   assign in_ram = (op_ff == cbm_pkg::OP_CPU_RD || op_ff == cbm_pkg::OP_CPU_WR)
                   && addr_ff[15:13] == 3'b011;
   assign ca     = cswap_ff ? (addr_ff ^ 16'h1000) : addr_ff;
   assign ram_we = cmd.exec && in_ram && op_ff == cbm_pkg::OP_CPU_WR
                   && ramen_ff && ramwe_ff;

   always_comb begin
      case (addr_ff[14:13])
         2'd0:    pbank = pswap_ff ? 8'(last8k - 7'd1) : bank_ff[6];
         2'd1:    pbank = bank_ff[7];
         2'd2:    pbank = pswap_ff ? bank_ff[6] : 8'(last8k - 7'd1);
         default: pbank = 8'(last8k);
      endcase
      if (!ca[12]) cbank = bank_ff[{2'b00, ca[11]}] & 8'hFE;
      else         cbank = bank_ff[3'd2 + {1'b0, ca[11:10]}];
   end

   always_comb begin
      st_c = cbm_pkg::ST_NONE;
      k_c  = 2'd0;
      case (op_ff)
         cbm_pkg::OP_CPU_RD, cbm_pkg::OP_CPU_WR: begin
            if (in_ram) st_c = cbm_pkg::ST_INNER;
            else if (addr_ff[15] && op_ff == cbm_pkg::OP_CPU_RD) begin
               st_c = cbm_pkg::ST_MAPPED;
               k_c  = 2'd1;
            end
         end
         cbm_pkg::OP_PPU_RD: begin
            if (addr_ff[15:13] == 3'd0) begin
               st_c = cbm_pkg::ST_MAPPED;
               k_c  = 2'd2;
            end
         end
         cbm_pkg::OP_PPU_WR: begin
            if (addr_ff[15:13] == 3'd0 && chr_ff == 6'd0) begin
               st_c = cbm_pkg::ST_MAPPED;
               k_c  = 2'd3;
            end
         end
         default: st_c = cbm_pkg::ST_NONE;
      endcase
   end

   assign tcnt = (cnt_ff == 8'd0 || reload_ff) ? latch_ff : cnt_ff - 8'd1;
   assign stat.mod_done = (shift_ff == 4'd0);

   cbm_ram #(.WIDTH(8), .DEPTH(WORK_RAM_DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (addr_ff[AW-1:0]),
      .wdata (data_ff),
      .rdata (ram_q)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_opcode;
         addr_ff <= req_address;
         data_ff <= req_write_data;
      end
      if (cmd.exec) begin
         st_ff    <= st_c;
         kind_ff  <= k_c;
         shift_ff <= 4'd8;
         if (k_c == 2'd1) begin
            rem_ff <= pbank;
            div_ff <= {2'b00, cnt8k};
            low_ff <= addr_ff[12:0];
         end else if (k_c == 2'd2) begin
            rem_ff <= cbank;
            div_ff <= cnt1k;
            low_ff <= {2'b00, ca[12] ? {1'b0, ca[9:0]} : ca[10:0]};
         end else begin
            rem_ff <= 8'd0;
            div_ff <= 9'd1;
            low_ff <= addr_ff[12:0];
         end
      end else if (cmd.mod_step && shift_ff != 4'd0) begin
         shift_ff <= shift_ff - 4'd1;
         // cnt1k may reach 504: 9 bits; compare divisor shifted by shift-1
         if (({8'd0, rem_ff} >> (shift_ff - 4'd1)) >= {7'd0, div_ff})
            rem_ff <= rem_ff - 8'(div_ff << (shift_ff - 4'd1));
      end
      if (cmd.finish) begin
         rsp_status    <= st_ff;
         rsp_read_data <= (st_ff == cbm_pkg::ST_INNER && op_ff == cbm_pkg::OP_CPU_RD)
                          ? (ramen_ff ? ram_q : 8'hFF) : 8'h00;
         case (kind_ff)
            2'd1:    rsp_mapped_offset <= {rem_ff[5:0], low_ff};
            2'd2:    rsp_mapped_offset <= {1'b0, rem_ff, 10'd0}
                                          + {8'd0, low_ff[10:0]};
            2'd3:    rsp_mapped_offset <= {6'd0, low_ff};
            default: rsp_mapped_offset <= 19'd0;
         endcase
         rsp_irq_pending    <= flag_ff;
         rsp_mirroring_mode <= mir_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) bank_ff[i] <= 8'd0;
         sel_ff <= 3'd0; pswap_ff <= 1'b0; cswap_ff <= 1'b0;
         mir_ff <= cbm_pkg::MIRR_VERT;
         ramen_ff <= 1'b1; ramwe_ff <= 1'b1;
         latch_ff <= 8'd0; cnt_ff <= 8'd0;
         irqen_ff <= 1'b0; reload_ff <= 1'b0; flag_ff <= 1'b0;
      end else begin
         if (csr_write && csr_index == cbm_pkg::CSR_MIRR)
            mir_ff <= csr_data[1] ? cbm_pkg::MIRR_FOUR : csr_data[1:0];
         if (cmd.exec && op_ff == cbm_pkg::OP_TICK) begin
            cnt_ff    <= tcnt;
            reload_ff <= 1'b0;
            if (tcnt == 8'd0 && irqen_ff) flag_ff <= 1'b1;
         end
         if (cmd.exec && op_ff == cbm_pkg::OP_CPU_WR && addr_ff[15]) begin
            case (addr_ff[14:13])
               2'd0: begin
                  if (!addr_ff[0]) begin
                     sel_ff   <= data_ff[2:0];
                     pswap_ff <= data_ff[6];
                     cswap_ff <= data_ff[7];
                  end else bank_ff[sel_ff] <= data_ff;
               end
               2'd1: begin
                  if (!addr_ff[0]) begin
                     if (!dmir_ff[1]) mir_ff <= {1'b0, data_ff[0]};
                  end else begin
                     ramen_ff <= data_ff[7];
                     ramwe_ff <= !data_ff[6];
                  end
               end
               2'd2: begin
                  if (!addr_ff[0]) latch_ff <= data_ff;
                  else begin
                     reload_ff <= 1'b1;
                     cnt_ff    <= 8'd0;
                  end
               end
               default: begin
                  irqen_ff <= addr_ff[0];
                  if (!addr_ff[0]) flag_ff <= 1'b0;
               end
            endcase
         end
      end
   end

   // config registers: two 16K program banks, character RAM, vertical
   always_ff @(posedge clock) begin
      if (reset) begin
         prg_ff  <= 6'd2;
         chr_ff  <= 6'd0;
         dmir_ff <= cbm_pkg::MIRR_VERT;
      end else if (csr_write) begin
         case (csr_index)
            cbm_pkg::CSR_PRG:  prg_ff  <= csr_data;
            cbm_pkg::CSR_CHR:  chr_ff  <= csr_data;
            cbm_pkg::CSR_MIRR: dmir_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end
endmodule

FILE: rtl/cartridge_bank_mapper_with_line_irq.sv
// Bank mapper with scanline IRQ counter: top level.
// A word is accepted only in the idle state, so one word is in flight; it then
// passes through the exec, modulo, RAM and output states in order, most of
// its time spent in the bank modulo unit. A stalled result holds off the next word.
// Synchronous active-high reset clears mapper and IRQ state and returns the
// config registers to their defaults; work RAM contents are kept.
module cartridge_bank_mapper_with_line_irq #(
   parameter int WORK_RAM_DEPTH = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [18:0] rsp_mapped_offset,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_irq_pending,
   output logic [1:0]  rsp_mirroring_mode,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_data
);
   cbm_pkg::cmd_type  cmd;
   cbm_pkg::stat_type stat;

   cbm_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .cmd
   );

   cbm_datapath #(.WORK_RAM_DEPTH(WORK_RAM_DEPTH)) u_dp (
      .clock, .reset, .cmd, .stat, .req_opcode, .req_address, .req_write_data,
      .csr_write, .csr_index, .csr_data, .rsp_status, .rsp_mapped_offset,
      .rsp_read_data, .rsp_irq_pending, .rsp_mirroring_mode
   );
endmodule

FILE: rtl/cbm_checker.sv
// Port-level checker for the bank mapper, bound to the top level.
// Depends on cbm_pkg and the assertion macro header.
`include "cartridge_bank_mapper_with_line_irq_assert.svh"
module cbm_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [7:0]  rsp_read_data,
   input logic [18:0] rsp_mapped_offset
);
   `CBM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `CBM_ASSERT_NXT(a_one_flight, clock, reset, req_valid && req_ready, !req_ready)
   `CBM_ASSERT_IMP(a_status_code, clock, reset, rsp_valid, rsp_status != 2'd3)
   `CBM_ASSERT_IMP(a_offset_zero, clock, reset, rsp_valid && rsp_status != cbm_pkg::ST_MAPPED, rsp_mapped_offset == 19'd0)
   `CBM_ASSERT_IMP(a_rdata_zero, clock, reset, rsp_valid && rsp_status != cbm_pkg::ST_INNER, rsp_read_data == 8'd0)
endmodule

bind cartridge_bank_mapper_with_line_irq cbm_port_checker u_chk (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_status, .rsp_read_data, .rsp_mapped_offset
);
